// ----- sv/sts_pkg.sv -----
`default_nettype none

package sts_pkg;

    localparam int POSITION_BITS_DEF = 16;

    // result queue; depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [15:0] DISPLAY_LEN = 16'd7;
    localparam logic [15:0] PROMPT_LEN  = 16'd6;

    typedef enum logic [3:0] {
        K_EOF     = 4'd0,
        K_DISPLAY = 4'd1,
        K_PROMPT  = 4'd2,
        K_IDENT   = 4'd3,
        K_NUMBER  = 4'd4,
        K_COLON   = 4'd5,
        K_PLUS    = 4'd6,
        K_MINUS   = 4'd7,
        K_STAR    = 4'd8,
        K_SLASH   = 4'd9,
        K_STRING  = 4'd10,
        K_ERROR   = 4'd11
    } t_kind;

    typedef enum logic [4:0] {
        M_IDLE    = 5'b00001,
        M_COMMENT = 5'b00010,
        M_WORD    = 5'b00100,
        M_NUMBER  = 5'b01000,
        M_STRING  = 5'b10000
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_pos;
        logic [15:0] text_len;
        logic [7:0]  bad_byte;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   push0;
        logic   push1;
        t_token tok0;
        t_token tok1;
    } t_lex_out;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [7:0] display_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64; // d
            3'd1:    c = 8'h69; // i
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h6C; // l
            3'd5:    c = 8'h61; // a
            3'd6:    c = 8'h79; // y
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] prompt_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h70; // p
            3'd1:    c = 8'h72; // r
            3'd2:    c = 8'h6F; // o
            3'd3:    c = 8'h6D; // m
            3'd4:    c = 8'h70; // p
            3'd5:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] len_inc(input logic [15:0] len);
        return (len == LEN_MAX) ? len : len + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sts_lexer.sv -----
`default_nettype none

module sts_lexer import sts_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_lex_out        o_res
);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_position, n_position;
    logic [15:0]              r_tok_start, n_tok_start;
    logic [15:0]              r_tok_len, n_tok_len;
    logic                     r_dm, n_dm;
    logic                     r_pm, n_pm;

    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS+15:0] p_ext, pn_ext;
    logic [15:0]              p16, pn16;
    logic                     word_ch;

    // what the byte does when seen from idle
    logic   id_emit;
    t_token id_tok;
    t_mode  id_mode;
    logic [15:0] id_start, id_len;
    logic   id_dm, id_pm;

    t_kind  word_kind;

    assign pos_next = r_position + 1'b1;
    assign p_ext    = {16'd0, r_position};
    assign pn_ext   = {16'd0, pos_next};
    assign p16      = p_ext[15:0];
    assign pn16     = pn_ext[15:0];
    assign word_ch  = is_alpha(i_byte) || is_digit(i_byte) || (i_byte == CH_UNDER);

    always_comb begin
        id_emit  = 1'b0;
        id_tok   = '{kind: K_ERROR, start_pos: p16, text_len: 16'd1,
                     bad_byte: i_byte, last: 1'b1};
        id_mode  = M_IDLE;
        id_start = r_tok_start;
        id_len   = r_tok_len;
        id_dm    = 1'b0;
        id_pm    = 1'b0;
        if (i_byte == CH_NUL) begin
            id_emit         = 1'b1;
            id_tok.kind     = K_EOF;
            id_tok.text_len = 16'd0;
            id_tok.bad_byte = 8'd0;
        end else if (is_space(i_byte)) begin
            id_emit = 1'b0;
        end else if (i_byte == CH_BANG) begin
            id_mode = M_COMMENT;
        end else if (is_alpha(i_byte) || i_byte == CH_UNDER) begin
            id_mode  = M_WORD;
            id_start = p16;
            id_len   = 16'd1;
            id_dm    = (i_byte == display_char(3'd0));
            id_pm    = (i_byte == prompt_char(3'd0));
        end else if (is_digit(i_byte)) begin
            id_mode  = M_NUMBER;
            id_start = p16;
            id_len   = 16'd1;
        end else if (i_byte == CH_QUOTE) begin
            id_mode  = M_STRING;
            id_start = pn16;
            id_len   = 16'd0;
        end else begin
            id_emit         = 1'b1;
            id_tok.bad_byte = 8'd0;
            case (i_byte)
                CH_COLON: id_tok.kind = K_COLON;
                CH_PLUS:  id_tok.kind = K_PLUS;
                CH_MINUS: id_tok.kind = K_MINUS;
                CH_STAR:  id_tok.kind = K_STAR;
                CH_SLASH: id_tok.kind = K_SLASH;
                default: begin
                    id_tok.kind     = K_ERROR;
                    id_tok.bad_byte = i_byte;
                end
            endcase
        end
    end

    always_comb begin
        if (r_dm && r_tok_len == DISPLAY_LEN) begin
            word_kind = K_DISPLAY;
        end else if (r_pm && r_tok_len == PROMPT_LEN) begin
            word_kind = K_PROMPT;
        end else begin
            word_kind = K_IDENT;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_position  = pos_next;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        n_dm        = r_dm;
        n_pm        = r_pm;
        o_res.push0 = 1'b0;
        o_res.push1 = 1'b0;
        o_res.tok0  = id_tok;
        o_res.tok1  = id_tok;

        unique case (r_mode)
            M_COMMENT: begin
                if (i_byte == CH_LF) begin
                    n_mode = M_IDLE;
                end else if (i_byte == CH_NUL) begin
                    o_res.push0 = 1'b1;
                end
            end
            M_WORD: begin
                if (word_ch) begin
                    n_dm = r_dm && (r_tok_len < DISPLAY_LEN) &&
                           (i_byte == display_char(r_tok_len[2:0]));
                    n_pm = r_pm && (r_tok_len < PROMPT_LEN) &&
                           (i_byte == prompt_char(r_tok_len[2:0]));
                    n_tok_len = len_inc(r_tok_len);
                end else begin
                    o_res.push0 = 1'b1;
                    o_res.push1 = id_emit;
                    o_res.tok0  = '{kind: word_kind, start_pos: r_tok_start,
                                    text_len: r_tok_len, bad_byte: 8'd0,
                                    last: !id_emit};
                    n_mode      = id_mode;
                    n_tok_start = id_start;
                    n_tok_len   = id_len;
                    n_dm        = id_dm;
                    n_pm        = id_pm;
                end
            end
            M_NUMBER: begin
                if (is_digit(i_byte)) begin
                    n_tok_len = len_inc(r_tok_len);
                end else begin
                    o_res.push0 = 1'b1;
                    o_res.push1 = id_emit;
                    o_res.tok0  = '{kind: K_NUMBER, start_pos: r_tok_start,
                                    text_len: r_tok_len, bad_byte: 8'd0,
                                    last: !id_emit};
                    n_mode      = id_mode;
                    n_tok_start = id_start;
                    n_tok_len   = id_len;
                    n_dm        = id_dm;
                    n_pm        = id_pm;
                end
            end
            M_STRING: begin
                if (i_byte == CH_QUOTE || i_byte == CH_NUL) begin
                    // an unterminated string closes at end of text, then eof
                    o_res.push0 = 1'b1;
                    o_res.push1 = (i_byte == CH_NUL);
                    o_res.tok0  = '{kind: K_STRING, start_pos: r_tok_start,
                                    text_len: r_tok_len, bad_byte: 8'd0,
                                    last: (i_byte == CH_QUOTE)};
                    n_mode      = M_IDLE;
                end else begin
                    n_tok_len = len_inc(r_tok_len);
                end
            end
            default: begin
                o_res.push0 = id_emit;
                n_mode      = id_mode;
                n_tok_start = id_start;
                n_tok_len   = id_len;
                n_dm        = id_dm;
                n_pm        = id_pm;
            end
        endcase

        if (i_byte == CH_NUL) begin
            n_mode      = M_IDLE;
            n_position  = '0;
            n_tok_start = 16'd0;
            n_tok_len   = 16'd0;
            n_dm        = 1'b0;
            n_pm        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_position  <= '0;
            r_tok_start <= 16'd0;
            r_tok_len   <= 16'd0;
            r_dm        <= 1'b0;
            r_pm        <= 1'b0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_position  <= n_position;
            r_tok_start <= n_tok_start;
            r_tok_len   <= n_tok_len;
            r_dm        <= n_dm;
            r_pm        <= n_pm;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sts_result_fifo.sv -----
`default_nettype none

module sts_result_fifo import sts_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_lex_out i_lex,
    input  wire logic     i_pop,
    output t_token        o_head,
    output logic          o_valid,
    output logic          o_room2
);

    t_token            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  wr1;
    logic              push0, push1;

    assign push0 = i_lex.push0;
    assign push1 = i_lex.push0 && i_lex.push1;
    assign wr1   = r_wr + 1'b1;

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for the two requests one byte can produce
    assign o_room2 = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    assign n_count = r_count + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_mem[r_wr] <= i_lex.tok0;
        end
        if (push1) begin
            r_mem[wr1] <= i_lex.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push1) begin
                r_wr <= r_wr + PTR_W'(2);
            end else if (push0) begin
                r_wr <= wr1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/script_token_scanner_top.sv -----
`default_nettype none

// Streaming lexer: takes one source byte per request (byte 0 ends the text) and
// returns tokens as kind, start offset and length, skipping whitespace and '!'
// comments. A byte is taken every cycle while input stall is low; it is held in
// the input register and scanned out of it once two queue entries are free, and
// its 0, 1 or 2 tokens land in a four-entry result queue at the next edge. The
// output port delivers one token per cycle while i_stall is low; bytes that yield
// two tokens (a word or number closed by a symbol, error or end of text, or a
// string closed by end of text) can fill the queue while the output is held off,
// and input stall rises while a byte waits in the input register and fewer than
// two entries are free. The last flag marks the final token of each byte.

module script_token_scanner_top import sts_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_start_pos,
    output logic [15:0]      o_text_len,
    output logic [7:0]       o_bad_byte,
    output logic             o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room2;
    logic       fire;
    logic       pop;
    t_lex_out   lex_res;
    t_token     head;

    assign fire    = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
        end
    end

    sts_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_byte  (r_in_byte),
        .o_res   (lex_res)
    );

    t_lex_out lex_gated;

    always_comb begin
        lex_gated       = lex_res;
        lex_gated.push0 = lex_res.push0 && fire;
        lex_gated.push1 = lex_res.push1 && fire;
    end

    sts_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lex   (lex_gated),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room2 (room2)
    );

    assign o_token_kind = head.kind;
    assign o_start_pos  = head.start_pos;
    assign o_text_len   = head.text_len;
    assign o_bad_byte   = head.bad_byte;
    assign o_last       = head.last;

endmodule

`default_nettype wire

// ----- test/sts_token_checker.sv -----
module sts_token_checker import sts_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [3:0]  i_token_kind,
    input  wire logic [15:0] i_start_pos,
    input  wire logic [15:0] i_text_len,
    input  wire logic [7:0]  i_bad_byte,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending
);

    localparam logic [55:0] DISPLAY_WORD = "display";
    localparam logic [47:0] PROMPT_WORD  = "prompt";

    // scanner state as the block should hold it
    t_mode       scan_state;
    logic [15:0] next_pos;
    logic [15:0] word_start;
    logic [15:0] word_len;
    logic        display_hit;
    logic        prompt_hit;

    t_token expected_tokens[$];
    int     fail_count;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [7:0] display_at(input int i);
        return DISPLAY_WORD[8*(6-i) +: 8];
    endfunction

    function automatic logic [7:0] prompt_at(input int i);
        return PROMPT_WORD[8*(5-i) +: 8];
    endfunction

    function automatic logic [15:0] grow(input logic [15:0] n);
        return (n == LEN_MAX) ? n : n + 16'd1;
    endfunction

    task automatic reset_scan();
        scan_state  = M_IDLE;
        next_pos    = '0;
        word_start  = '0;
        word_len    = '0;
        display_hit = 1'b0;
        prompt_hit  = 1'b0;
    endtask

    task automatic add_token(input t_kind k, input logic [15:0] s, input logic [15:0] l,
                             input logic [7:0] bad);
        t_token t;
        t.kind      = k;
        t.start_pos = s;
        t.text_len  = l;
        t.bad_byte  = bad;
        t.last      = 1'b0;
        expected_tokens.push_back(t);
    endtask

    // byte seen with no token open
    task automatic open_token(input logic [7:0] b, input logic [15:0] p);
        if (b == CH_NUL) begin
            add_token(K_EOF, p, 16'd0, 8'd0);
        end else if (b == CH_BANG) begin
            scan_state = M_COMMENT;
        end else if (is_letter(b) || b == CH_UNDER) begin
            scan_state  = M_WORD;
            word_start  = p;
            word_len    = 16'd1;
            display_hit = (b == display_at(0));
            prompt_hit  = (b == prompt_at(0));
        end else if (is_num(b)) begin
            scan_state = M_NUMBER;
            word_start = p;
            word_len   = 16'd1;
        end else if (b == CH_QUOTE) begin
            scan_state = M_STRING;
            word_start = p + 16'd1;
            word_len   = 16'd0;
        end else if (!is_blank(b)) begin
            case (b)
                CH_COLON: add_token(K_COLON, p, 16'd1, 8'd0);
                CH_PLUS:  add_token(K_PLUS,  p, 16'd1, 8'd0);
                CH_MINUS: add_token(K_MINUS, p, 16'd1, 8'd0);
                CH_STAR:  add_token(K_STAR,  p, 16'd1, 8'd0);
                CH_SLASH: add_token(K_SLASH, p, 16'd1, 8'd0);
                default:  add_token(K_ERROR, p, 16'd1, b);
            endcase
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        logic [15:0] p;
        int          n_old;
        t_kind       kind;
        t_token      t;
        p        = next_pos;
        next_pos = p + 16'd1;
        n_old    = expected_tokens.size();
        case (scan_state)
            M_COMMENT: begin
                if (b == CH_LF) begin
                    scan_state = M_IDLE;
                end else if (b == CH_NUL) begin
                    open_token(b, p);
                end
            end
            M_WORD: begin
                if (is_letter(b) || is_num(b) || b == CH_UNDER) begin
                    display_hit = display_hit && word_len < 16'd7
                                  && b == display_at(int'(word_len));
                    prompt_hit  = prompt_hit && word_len < 16'd6
                                  && b == prompt_at(int'(word_len));
                    word_len    = grow(word_len);
                end else begin
                    if (display_hit && word_len == 16'd7) begin
                        kind = K_DISPLAY;
                    end else if (prompt_hit && word_len == 16'd6) begin
                        kind = K_PROMPT;
                    end else begin
                        kind = K_IDENT;
                    end
                    add_token(kind, word_start, word_len, 8'd0);
                    scan_state  = M_IDLE;
                    display_hit = 1'b0;
                    prompt_hit  = 1'b0;
                    open_token(b, p);
                end
            end
            M_NUMBER: begin
                if (is_num(b)) begin
                    word_len = grow(word_len);
                end else begin
                    add_token(K_NUMBER, word_start, word_len, 8'd0);
                    scan_state = M_IDLE;
                    open_token(b, p);
                end
            end
            M_STRING: begin
                if (b == CH_QUOTE) begin
                    add_token(K_STRING, word_start, word_len, 8'd0);
                    scan_state = M_IDLE;
                end else if (b == CH_NUL) begin
                    // unterminated string: string token, then eof
                    add_token(K_STRING, word_start, word_len, 8'd0);
                    scan_state = M_IDLE;
                    open_token(b, p);
                end else begin
                    word_len = grow(word_len);
                end
            end
            default: begin
                scan_state = M_IDLE;
                open_token(b, p);
            end
        endcase
        if (b == CH_NUL) begin
            reset_scan();
        end
        if (expected_tokens.size() > n_old) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            reset_scan();
            expected_tokens.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_text_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                got.kind      = t_kind'(i_token_kind);
                got.start_pos = i_start_pos;
                got.text_len  = i_text_len;
                got.bad_byte  = i_bad_byte;
                got.last      = i_last;
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no token", $time);
                    $display("%0t: actual kind %0d start %0d len %0d bad %0d last %0d",
                             $time, got.kind, got.start_pos, got.text_len, got.bad_byte,
                             got.last);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.kind !== want.kind || got.start_pos !== want.start_pos
                        || got.text_len !== want.text_len || got.bad_byte !== want.bad_byte
                        || got.last !== want.last) begin
                        fail_count++;
                        $display("%0t: expected kind %0d start %0d len %0d bad %0d last %0d",
                                 $time, want.kind, want.start_pos, want.text_len,
                                 want.bad_byte, want.last);
                        $display("%0t: actual   kind %0d start %0d len %0d bad %0d last %0d",
                                 $time, got.kind, got.start_pos, got.text_len,
                                 got.bad_byte, got.last);
                    end
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= expected_tokens.size();
    end

endmodule

// ----- test/tb_script_token_scanner_top.sv -----
module tb_script_token_scanner_top import sts_pkg::*; ();

    localparam int TARGET_BYTES = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        i_stall;
    logic [7:0]  i_text_byte;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_start_pos;
    logic [15:0] o_text_len;
    logic [7:0]  o_bad_byte;
    logic        o_last;

    int   errors;
    int   pending;
    int   counted;
    int   stall_left;
    logic idle_on;
    logic counting;

    script_token_scanner_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_token_kind (o_token_kind),
        .o_start_pos  (o_start_pos),
        .o_text_len   (o_text_len),
        .o_bad_byte   (o_bad_byte),
        .o_last       (o_last)
    );

    sts_token_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_text_byte  (i_text_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_token_kind (o_token_kind),
        .i_start_pos  (o_start_pos),
        .i_text_len   (o_text_len),
        .i_bad_byte   (o_bad_byte),
        .i_last       (o_last),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result-side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    i_stall    <= 1'b1;
                    stall_left <= pick_gap();
                end
                2: begin
                    i_stall    <= 1'b0;
                    stall_left <= $urandom_range(30, 120);
                end
                default: begin
                    i_stall    <= 1'b0;
                    stall_left <= $urandom_range(0, 4);
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (counting) counted++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // hold off new requests until every expected token is out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic string keyword_variant();
        case ($urandom_range(0, 11))
            0:       return "display";
            1:       return "prompt";
            2:       return "displa";
            3:       return "promptx";
            4:       return "prompt9";
            5:       return "disp_lay";
            6:       return "Display";
            7:       return "displayy";
            8:       return "_prompt";
            9:       return "pr";
            10:      return "d";
            default: return "p";
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return 8'(8'h61 + $urandom_range(0, 25));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            2:       return 8'(8'h30 + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] junk_byte();
        string punct;
        int    r;
        punct = "#$%&'(),.;<=>?@[\\]^{|}~";
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(1, 8));
            1: begin
                r = $urandom_range(14, 32);
                return (r == 32) ? 8'h7F : 8'(r);
            end
            2: return 8'($urandom_range(128, 255));
            default: return punct[$urandom_range(0, punct.len() - 1)];
        endcase
    endfunction

    task automatic send_phrase();
        int         sel;
        int         n;
        int         k;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            send_text(keyword_variant());
        end else if (sel < 24) begin
            k = $urandom_range(0, 25);
            case ($urandom_range(0, 3))
                0:       c = CH_UNDER;
                1:       c = 8'(8'h41 + k);
                default: c = 8'(8'h61 + k);
            endcase
            send_byte(c);
            n = $urandom_range(0, 8);
            repeat (n) send_byte(word_char());
        end else if (sel < 34) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'(8'h30 + $urandom_range(0, 9)));
        end else if (sel < 48) begin
            case ($urandom_range(0, 4))
                0:       send_byte(CH_COLON);
                1:       send_byte(CH_PLUS);
                2:       send_byte(CH_MINUS);
                3:       send_byte(CH_STAR);
                default: send_byte(CH_SLASH);
            endcase
        end else if (sel < 60) begin
            send_byte(CH_QUOTE);
            n = $urandom_range(0, 10);
            repeat (n) begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_QUOTE) c = 8'h27;
                send_byte(c);
            end
            // now and then the string stays open
            if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
        end else if (sel < 66) begin
            send_byte(CH_BANG);
            n = $urandom_range(0, 8);
            repeat (n) begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_LF) c = 8'h20;
                send_byte(c);
            end
            if ($urandom_range(0, 9) != 0) send_byte(CH_LF);
        end else if (sel < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                k = $urandom_range(0, 5);
                send_byte(k == 0 ? 8'h20 : 8'(8'h08 + k));
            end
        end else if (sel < 87) begin
            send_byte(junk_byte());
        end else if (sel < 96) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(CH_NUL);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_text_byte <= 8'h00;
        idle_on     = 1'b1;
        counting    = 1'b0;
        counted     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keywords, every symbol, words closed by symbols, strings, comments, bad bytes
        send_text("display:prompt-_a1*9/+\"x\"!c\n#");
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CH_NUL);
        // string left open at end of text, then comment at end of text
        send_text("\"q");
        send_byte(CH_NUL);
        send_byte(CH_BANG);
        send_byte(CH_NUL);
        drain();

        counting = 1'b1;
        while (counted < TARGET_BYTES) begin
            if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
            send_phrase();
            if ($urandom_range(0, 59) == 0) drain();
        end
        send_byte(CH_NUL);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
